>>> src/frad_pkg.sv
// ----------------------------------------------------------------------------
// frad_pkg: shared types and constants of the fork rate acceleration detector
// Holds the table geometry, the register map, the controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package frad_pkg;

   // Table geometry.
   localparam int CONTAINER_SLOTS = 64;
   localparam int SLOT_IDX_W      = (CONTAINER_SLOTS > 1) ? $clog2(CONTAINER_SLOTS) : 1;

   // Field widths.
   localparam int SLOT_W  = 6;
   localparam int CID_W   = 64;
   localparam int PID_W   = 32;
   localparam int TIME_W  = 64;
   localparam int COUNT_W = 32;

   // One table row: window start and three window counts.
   localparam int ROW_W = TIME_W + 3 * COUNT_W;

   // Configuration register map.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_FLOOR    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HARD_CEILING  = 2'd2;

   // Register reset values.
   localparam logic [TIME_W-1:0]  WINDOW_LENGTH_RESET = 64'd1000000000;
   localparam logic [COUNT_W-1:0] RATE_FLOOR_RESET    = 32'd50;
   localparam logic [COUNT_W-1:0] HARD_CEILING_RESET  = 32'd500;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_JUDGE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read;
      logic eval;
      logic load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

endpackage

>>> src/fork_rate_acceleration_detector_unit.sv
// ----------------------------------------------------------------------------
// fork_rate_acceleration_detector_unit: per-container fork rate watchdog
// Counts fork events per container slot over time windows and flags
// accelerating fork rates and counts above a hard ceiling.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one fork event per beat (slot, container id,
// process id, timestamp). The rsp_ channel returns exactly one verdict beat
// per event, in order: kill and alert flags, the window count after the
// event, and the event's identity echoed when an alert fires.
// Each event runs from its accepting edge to rsp_valid through the registered
// read of the slot table, the window update that writes the row back, and the
// verdict that loads the output register. The controller walks one event
// through idle, read, update and verdict before it takes the next.
// The verdict sits in an output register, so the next event is accepted
// while it waits. When rsp_stall holds, a second verdict waits inside the
// block and req_stall stays high until the output register frees up.
// Reset (synchronous) empties all slots, drops any pending verdict and loads
// the default window length, rate floor and ceiling. The user writes the csr_
// port only while the block is idle, not enforced; writes take effect at once.
// ----------------------------------------------------------------------------
module fork_rate_acceleration_detector_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [frad_pkg::SLOT_W-1:0]      req_container_slot,
   input  logic [frad_pkg::CID_W-1:0]       req_container_id,
   input  logic [frad_pkg::PID_W-1:0]       req_process_id,
   input  logic [frad_pkg::TIME_W-1:0]      req_event_time_ns,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_kill_request,
   output logic                             rsp_accel_alert,
   output logic [frad_pkg::COUNT_W-1:0]     rsp_window_count,
   output logic [frad_pkg::CID_W-1:0]       rsp_alert_container,
   output logic [frad_pkg::PID_W-1:0]       rsp_alert_process,
   output logic [frad_pkg::TIME_W-1:0]      rsp_alert_time,
   input  logic                             csr_write_enable,
   input  logic [frad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [frad_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import frad_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencing controller.
   frad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Table, window update and verdict.
   frad_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_container_slot  (req_container_slot),
      .req_container_id    (req_container_id),
      .req_process_id      (req_process_id),
      .req_event_time_ns   (req_event_time_ns),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kill_request    (rsp_kill_request),
      .rsp_accel_alert     (rsp_accel_alert),
      .rsp_window_count    (rsp_window_count),
      .rsp_alert_container (rsp_alert_container),
      .rsp_alert_process   (rsp_alert_process),
      .rsp_alert_time      (rsp_alert_time)
   );

endmodule

>>> src/frad_ram.sv
// ----------------------------------------------------------------------------
// frad_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module frad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_address,
   input  logic [WIDTH-1:0]  write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_address,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Storage and registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> src/frad_ctrl.sv
// ----------------------------------------------------------------------------
// frad_ctrl: sequencing controller
// Walks one fork event through table read, window update and verdict, and
// holds the input side stalled until the verdict is in the output register.
// ----------------------------------------------------------------------------
module frad_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output frad_pkg::ctrl_cmd_type    cmd,
   input  frad_pkg::ctrl_status_type status
);
   import frad_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            // Wait here until the output register can take the verdict.
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/frad_datapath.sv
// ----------------------------------------------------------------------------
// frad_datapath: slot table, window update and acceleration verdict
// Holds the configuration registers, the per-slot valid bits, the slot table
// memory, the working registers of one event and the output register.
// ----------------------------------------------------------------------------
module frad_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  frad_pkg::ctrl_cmd_type            cmd,
   output frad_pkg::ctrl_status_type         status,
   input  logic                              csr_write_enable,
   input  logic [frad_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [frad_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic [frad_pkg::SLOT_W-1:0]       req_container_slot,
   input  logic [frad_pkg::CID_W-1:0]        req_container_id,
   input  logic [frad_pkg::PID_W-1:0]        req_process_id,
   input  logic [frad_pkg::TIME_W-1:0]       req_event_time_ns,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kill_request,
   output logic                              rsp_accel_alert,
   output logic [frad_pkg::COUNT_W-1:0]      rsp_window_count,
   output logic [frad_pkg::CID_W-1:0]        rsp_alert_container,
   output logic [frad_pkg::PID_W-1:0]        rsp_alert_process,
   output logic [frad_pkg::TIME_W-1:0]       rsp_alert_time
);
   import frad_pkg::*;

   // Configuration registers.
   logic [TIME_W-1:0]  window_length_ff;
   logic [COUNT_W-1:0] rate_floor_ff;
   logic [COUNT_W-1:0] hard_ceiling_ff;

   // Captured event.
   logic [SLOT_W-1:0] slot_ff;
   logic [CID_W-1:0]  cid_ff;
   logic [PID_W-1:0]  pid_ff;
   logic [TIME_W-1:0] time_ff;
   logic              in_range_ff;

   // Updated counts of the event's slot.
   logic [COUNT_W-1:0] cur_ff;
   logic [COUNT_W-1:0] prev_ff;
   logic [COUNT_W-1:0] early_ff;
   logic               first_ff;

   // Per-slot valid bits.
   logic [CONTAINER_SLOTS-1:0] entry_valid_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic               kill_ff;
   logic               accel_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [CID_W-1:0]   echo_cid_ff;
   logic [PID_W-1:0]   echo_pid_ff;
   logic [TIME_W-1:0]  echo_time_ff;

   // Table access.
   logic [SLOT_IDX_W-1:0] slot_idx;
   logic [ROW_W-1:0]      row_rd;
   logic [ROW_W-1:0]      row_wr;
   logic                  row_we;
   logic [TIME_W-1:0]     rd_begin;
   logic [COUNT_W-1:0]    rd_cur;
   logic [COUNT_W-1:0]    rd_prev;
   logic [COUNT_W-1:0]    rd_early;

   // Window update.
   logic               slot_valid;
   logic [TIME_W-1:0]  elapsed;
   logic               rotate;
   logic [TIME_W-1:0]  new_begin;
   logic [COUNT_W-1:0] new_cur;
   logic [COUNT_W-1:0] new_prev;
   logic [COUNT_W-1:0] new_early;

   // Verdict.
   logic               accel;
   logic               kill;
   logic [COUNT_W:0]   d2_sum;
   logic [COUNT_W:0]   d2_twice;

   // Configuration writes; indexes beyond the map are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
         rate_floor_ff    <= RATE_FLOOR_RESET;
         hard_ceiling_ff  <= HARD_CEILING_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_write_data;
            CSR_RATE_FLOOR:    rate_floor_ff    <= csr_write_data[COUNT_W-1:0];
            CSR_HARD_CEILING:  hard_ceiling_ff  <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture of the accepted beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff     <= req_container_slot;
         cid_ff      <= req_container_id;
         pid_ff      <= req_process_id;
         time_ff     <= req_event_time_ns;
         in_range_ff <= (32'(req_container_slot) < CONTAINER_SLOTS);
      end
   end

   assign slot_idx = SLOT_IDX_W'(slot_ff);

   // Slot table memory.
   frad_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CONTAINER_SLOTS)
   ) u_table (
      .clock         (clock),
      .write_enable  (row_we),
      .write_address (slot_idx),
      .write_data    (row_wr),
      .read_enable   (cmd.read),
      .read_address  (slot_idx),
      .read_data     (row_rd)
   );

   assign {rd_begin, rd_cur, rd_prev, rd_early} = row_rd;

   // Window rotation or saturating increment; a fresh slot starts over.
   always_comb begin
      slot_valid = entry_valid_ff[slot_idx];
      elapsed    = time_ff - rd_begin;
      rotate     = (elapsed > window_length_ff);
      new_begin  = rd_begin;
      new_cur    = rd_cur;
      new_prev   = rd_prev;
      new_early  = rd_early;
      if (!slot_valid) begin
         new_begin = time_ff;
         new_cur   = COUNT_W'(1);
         new_prev  = '0;
         new_early = '0;
      end else if (rotate) begin
         new_begin = time_ff;
         new_cur   = COUNT_W'(1);
         new_prev  = rd_cur;
         new_early = rd_prev;
      end else if (rd_cur != '1) begin
         new_cur = rd_cur + COUNT_W'(1);
      end
   end

   assign row_we = cmd.eval && in_range_ff;
   assign row_wr = {new_begin, new_cur, new_prev, new_early};

   // Valid bits and updated counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (row_we) begin
         entry_valid_ff[slot_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         cur_ff   <= new_cur;
         prev_ff  <= new_prev;
         early_ff <= new_early;
         first_ff <= !slot_valid;
      end
   end

   // Acceleration and kill verdict on the updated counts.
   always_comb begin
      d2_sum   = {1'b0, cur_ff} + {1'b0, early_ff};
      d2_twice = {prev_ff, 1'b0};
      accel    = in_range_ff && !first_ff
                 && (cur_ff > rate_floor_ff)
                 && (prev_ff != '0) && (early_ff != '0)
                 && (d2_sum > d2_twice)
                 && (cur_ff > prev_ff) && (prev_ff > early_ff);
      kill     = in_range_ff && !first_ff && (accel || (cur_ff > hard_ceiling_ff));
   end

   // Output register; it frees up in the cycle its beat is taken.
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kill_ff      <= kill;
         accel_ff     <= accel;
         count_ff     <= in_range_ff ? cur_ff : '0;
         echo_cid_ff  <= accel ? cid_ff : '0;
         echo_pid_ff  <= accel ? pid_ff : '0;
         echo_time_ff <= accel ? time_ff : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kill_request    = kill_ff;
   assign rsp_accel_alert     = accel_ff;
   assign rsp_window_count    = count_ff;
   assign rsp_alert_container = echo_cid_ff;
   assign rsp_alert_process   = echo_pid_ff;
   assign rsp_alert_time      = echo_time_ff;

endmodule
